>>> src/lcm_pkg.sv
// ============================================================================
// lcm_pkg: shared types for the gcd / lcm block
// Request and result payloads, plus the command and status bundles that
// join the controller to the datapath.
// ============================================================================
package lcm_pkg;

  // Request payload: two unsigned operands
  typedef struct packed {
    logic [31:0] first_operand;
    logic [31:0] second_operand;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [31:0] common_divisor;
    logic [63:0] common_multiple;
    logic        both_zero;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture request operands
    logic gcd_step;    // one binary gcd reduction step
    logic gcd_finish;  // form divisor, arm the divider
    logic div_step;    // one restoring division step
    logic mul_step;    // quotient times second operand
    logic out_load;    // move finished result to output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic trivial;     // request has a zero operand
    logic gcd_done;    // one of the gcd working values reached zero
    logic div_last;    // final division step is due
  } status_t;

endpackage

>>> src/lcm_datapath.sv
// ============================================================================
// lcm_datapath: operand registers, gcd reducer, divider and multiplier
// Binary gcd (shift / subtract per cycle), then a one-bit-per-cycle
// restoring divide of the first operand by the divisor, then one multiply.
// ============================================================================
module lcm_datapath #(
  parameter int W = 32
) (
  input  logic            clk,
  input  lcm_pkg::req_t   req_data,
  input  lcm_pkg::cmd_t   cmd,
  output lcm_pkg::status_t sts,
  output lcm_pkg::res_t   res_data
);

  localparam int KW = $clog2(W);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]   opa;
  logic [W-1:0]   opb;
  logic [W-1:0]   u;
  logic [W-1:0]   v;
  logic [KW-1:0]  k;
  logic [W-1:0]   g;
  logic [W-1:0]   rem;
  logic [W-1:0]   quo;
  logic [CW-1:0]  cnt;
  logic [2*W-1:0] prod;
  logic           both_zero;

  logic [W-1:0]   in_a;
  logic [W-1:0]   in_b;
  logic [W-1:0]   u_next;
  logic [W-1:0]   v_next;
  logic [KW-1:0]  k_next;
  logic [W-1:0]   u_minus_v;
  logic [W-1:0]   v_minus_u;
  logic [W:0]     rem_shift;
  logic [W:0]     rem_sub;
  logic           rem_ge;

  // Keep only the low W bits of each operand
  assign in_a = W'(req_data.first_operand);
  assign in_b = W'(req_data.second_operand);

  assign sts.trivial  = (in_a == '0) || (in_b == '0);
  assign sts.gcd_done = (u == '0) || (v == '0);
  assign sts.div_last = (cnt == CW'(1));

  // Binary gcd step: strip common twos, strip lone twos, else subtract and halve
  assign u_minus_v = u - v;
  assign v_minus_u = v - u;

  always_comb begin
    u_next = u;
    v_next = v;
    k_next = k;
    priority if (!u[0] && !v[0]) begin
      u_next = u >> 1;
      v_next = v >> 1;
      k_next = k + KW'(1);
    end else if (!u[0]) begin
      u_next = u >> 1;
    end else if (!v[0]) begin
      v_next = v >> 1;
    end else if (u >= v) begin
      u_next = u_minus_v >> 1;
    end else begin
      v_next = v_minus_u >> 1;
    end
  end

  // Restoring division step
  assign rem_shift = {rem, quo[W-1]};
  assign rem_ge    = rem_shift >= {1'b0, g};
  assign rem_sub   = rem_shift - {1'b0, g};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opa       <= in_a;
      opb       <= in_b;
      u         <= in_a;
      v         <= in_b;
      k         <= '0;
      g         <= in_a | in_b;
      prod      <= '0;
      both_zero <= (in_a == '0) && (in_b == '0);
    end
    if (cmd.gcd_step) begin
      u <= u_next;
      v <= v_next;
      k <= k_next;
    end
    if (cmd.gcd_finish) begin
      g   <= (u | v) << k;
      rem <= '0;
      quo <= opa;
      cnt <= CW'(W);
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? rem_sub[W-1:0] : rem_shift[W-1:0];
      quo <= {quo[W-2:0], rem_ge};
      cnt <= cnt - CW'(1);
    end
    if (cmd.mul_step) begin
      prod <= (2*W)'(quo) * (2*W)'(opb);
    end
    if (cmd.out_load) begin
      res_data.common_divisor  <= 32'(g);
      res_data.common_multiple <= 64'(prod);
      res_data.both_zero       <= both_zero;
    end
  end

endmodule

>>> src/lcm_ctrl.sv
// ============================================================================
// lcm_ctrl: sequencer for the gcd / lcm block
// Walks idle, gcd, divide, multiply and done phases and owns result valid.
// ============================================================================
module lcm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             res_valid,
  input  logic             res_ready,
  input  lcm_pkg::status_t sts,
  output lcm_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    GCD,
    DIV,
    MUL,
    DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == IDLE);

  // Decode commands and next phase
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        cmd.load = req_valid;
        if (req_valid) begin
          state_next = sts.trivial ? DONE : GCD;
        end
      end
      GCD: begin
        if (sts.gcd_done) begin
          cmd.gcd_finish = 1'b1;
          state_next     = DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = MUL;
        end
      end
      MUL: begin
        cmd.mul_step = 1'b1;
        state_next   = DONE;
      end
      DONE: begin
        cmd.out_load = !res_valid || res_ready;
        if (cmd.out_load) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // Hold phase and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/lcm_via_euclid_gcd.sv
// ============================================================================
// lcm_via_euclid_gcd: greatest common divisor and least common multiple
// Returns gcd(a, b) and lcm(a, b) = (a / gcd) * b for two unsigned operands.
// ============================================================================
//
//   channel   direction  payload        handshake
//   -------   ---------  -------------  ----------------------
//   req       in         lcm_pkg::req_t req_valid / req_ready
//   res       out        lcm_pkg::res_t res_valid / res_ready
//
// A request with a zero operand goes from the accept straight to the result load.
// Otherwise: the accept, the gcd steps (one shift or subtract each, a final
// gcd step forms the divisor), the divider steps, one multiply and one
// result load, which waits while an earlier result is still unread.
// One request is worked at a time; the output register lets the next
// request be accepted while a result waits for res_ready.
// Reset is synchronous and clears only the sequencer and result valid.
// ============================================================================
module lcm_via_euclid_gcd #(
  parameter int OPERAND_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lcm_pkg::req_t req_data,
  output logic          res_valid,
  input  logic          res_ready,
  output lcm_pkg::res_t res_data
);

  lcm_pkg::cmd_t    cmd;
  lcm_pkg::status_t sts;

  lcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lcm_datapath #(
    .W (OPERAND_BITS)
  ) u_datapath (
    .clk      (clk),
    .req_data (req_data),
    .cmd      (cmd),
    .sts      (sts),
    .res_data (res_data)
  );

`ifndef SYNTHESIS
  // Busy after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while a previous one is in flight");

  // Both-zero result carries zero divisor and multiple
  a_both_zero_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.both_zero) |->
      (res_data.common_divisor == 32'd0 && res_data.common_multiple == 64'd0))
    else $error("both_zero result with nonzero fields");

  // Any other result has a nonzero divisor
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.both_zero) |-> (res_data.common_divisor != 32'd0))
    else $error("zero divisor on a regular result");
`endif

endmodule

>>> verif/tb.sv
// ============================================================================
// tb: testbench for the gcd / lcm block
// Drives operand pairs through the request channel with random gaps and
// back-to-back stretches. A scoreboard computes the divisor and multiple of
// every accepted request and checks each result, in order, field by field.
// The run covers zero operands, extreme values, worst-case Euclid chains,
// shared-factor pairs and random noise. It also holds the result side off
// for a long stretch so that the request side backs up.
// ============================================================================
module tb;

  localparam int OPERAND_BITS = 32;
  localparam logic [31:0] OPERAND_MASK = 32'((64'd1 << OPERAND_BITS) - 64'd1);
  localparam int RANDOM_REQUESTS = 1625;
  localparam int MAX_GAP = 6;
  localparam int HOLD_OFF_CYCLES = 500;
  localparam int HOLD_OFF_AT = 400;
  localparam int DRAIN_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;

  // Reference arithmetic and in-order result store
  class lcm_scoreboard;
    lcm_pkg::res_t pending_results[$];
    int   mismatches;
    int   requests_noted;
    int   results_checked;
    int   zero_operand_requests;
    int   both_zero_requests;

    function new();
      mismatches = 0;
      requests_noted = 0;
      results_checked = 0;
      zero_operand_requests = 0;
      both_zero_requests = 0;
    endfunction

    // Euclid on the masked operands, then lcm = (a / gcd) * b
    function lcm_pkg::res_t predict_gcd_lcm(lcm_pkg::req_t r);
      logic [31:0]   a;
      logic [31:0]   b;
      logic [31:0]   x;
      logic [31:0]   y;
      logic [31:0]   t;
      lcm_pkg::res_t e;
      a = r.first_operand & OPERAND_MASK;
      b = r.second_operand & OPERAND_MASK;
      e = '0;
      if (a == 0 && b == 0) begin
        e.both_zero = 1'b1;
        return e;
      end
      x = a;
      y = b;
      if (x < y) begin
        t = x;
        x = y;
        y = t;
      end
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      e.common_divisor = x;
      if (a != 0 && b != 0) begin
        e.common_multiple = 64'(a / x) * 64'(b);
      end
      return e;
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      mismatches++;
    endtask

    function void note_request(lcm_pkg::req_t r);
      logic [31:0] a;
      logic [31:0] b;
      a = r.first_operand & OPERAND_MASK;
      b = r.second_operand & OPERAND_MASK;
      requests_noted++;
      if (a == 0 && b == 0) begin
        both_zero_requests++;
      end else if (a == 0 || b == 0) begin
        zero_operand_requests++;
      end
      pending_results.push_back(predict_gcd_lcm(r));
    endfunction

    task check_result(lcm_pkg::res_t got);
      lcm_pkg::res_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding (gcd %0d lcm %0d)",
                         results_checked, got.common_divisor, got.common_multiple));
        return;
      end
      want = pending_results.pop_front();
      if (got.common_divisor !== want.common_divisor) begin
        report($sformatf("result %0d common_divisor got %0d want %0d",
                         results_checked, got.common_divisor, want.common_divisor));
      end
      if (got.common_multiple !== want.common_multiple) begin
        report($sformatf("result %0d common_multiple got %0d want %0d",
                         results_checked, got.common_multiple, want.common_multiple));
      end
      if (got.both_zero !== want.both_zero) begin
        report($sformatf("result %0d both_zero got %b want %b",
                         results_checked, got.both_zero, want.both_zero));
      end
    endtask
  endclass

  logic          clk;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  lcm_pkg::req_t req_data  = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  lcm_pkg::res_t res_data;

  lcm_scoreboard sb = new();
  logic [31:0]   fib_seq [48];
  int            stall_cycles = 0;
  bit            held_off = 0;

  lcm_via_euclid_gcd #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request after a random gap; hold it until accepted
  task automatic send_request(input logic [31:0] a, input logic [31:0] b, input int idx);
    int            gap;
    lcm_pkg::req_t r;
    r.first_operand = a;
    r.second_operand = b;
    // every fourth block of 64 requests runs back to back
    gap = ((idx / 64) % 4 == 3) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(r);
  endtask

  // Draw one operand pair from a mix of shapes
  task automatic random_pair(output logic [31:0] a, output logic [31:0] b);
    int          kind;
    int          k;
    logic [31:0] g;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      a = $urandom;
      b = $urandom;
    end else if (kind < 55) begin
      // shared factor g, so the divisor is a multiple of g and the multiple is reduced by it
      g = $urandom_range(1, 32'd1 << $urandom_range(0, 20));
      a = g * $urandom_range(1, 32'hFFFF_FFFF / g);
      b = g * $urandom_range(1, 32'hFFFF_FFFF / g);
    end else if (kind < 70) begin
      a = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
    end else if (kind < 80) begin
      a = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
      b = 32'd0;
      if ($urandom_range(0, 1)) begin
        b = a;
        a = 32'd0;
      end
    end else if (kind < 90) begin
      // neighboring Fibonacci numbers give the longest remainder chains
      k = $urandom_range(1, 46);
      a = fib_seq[k + 1];
      b = fib_seq[k];
      if ($urandom_range(0, 1)) begin
        a = fib_seq[k];
        b = fib_seq[k + 1];
      end
    end else begin
      a = ~32'($urandom_range(0, 255));
      b = $urandom_range(0, 1) ? ~32'($urandom_range(0, 255)) : $urandom;
    end
  endtask

  // Accept results with random stalls, one long hold-off, and no-stall stretches
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && sb.results_checked == HOLD_OFF_AT) begin
        held_off = 1;
        gap = HOLD_OFF_CYCLES;
      end else if ((sb.results_checked / 64) % 4 == 1) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      sb.check_result(res_data);
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (res_valid && res_ready) || rst) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("TIMEOUT: nothing accepted for %0d cycles, %0d results outstanding",
               STALL_LIMIT, sb.pending_results.size());
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Main sequence: reset, directed pairs, random pairs, drain
  initial begin
    logic [31:0] a;
    logic [31:0] b;
    int          n;
    fib_seq[0] = 32'd0;
    fib_seq[1] = 32'd1;
    for (int i = 2; i < 48; i++) begin
      fib_seq[i] = fib_seq[i - 1] + fib_seq[i - 2];
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero operands
    n = 0;
    send_request(32'd0, 32'd0, n++);
    send_request(32'd0, 32'd1, n++);
    send_request(32'd1, 32'd0, n++);
    send_request(32'd0, 32'hFFFF_FFFF, n++);
    send_request(32'hFFFF_FFFF, 32'd0, n++);
    send_request(32'd0, 32'h8000_0000, n++);
    // extremes and equal operands
    send_request(32'd1, 32'd1, n++);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, n++);
    send_request(32'hFFFF_FFFF, 32'd1, n++);
    send_request(32'd1, 32'hFFFF_FFFF, n++);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE, n++);
    send_request(32'h8000_0000, 32'h8000_0000, n++);
    send_request(32'h8000_0000, 32'h4000_0000, n++);
    send_request(32'h1234_5678, 32'h1234_5678, n++);
    // worst-case remainder chain, both orders
    send_request(fib_seq[47], fib_seq[46], n++);
    send_request(fib_seq[46], fib_seq[47], n++);
    // first smaller than second, then larger
    send_request(32'd12, 32'd18, n++);
    send_request(32'd18, 32'd12, n++);
    // two large primes: the multiple is the full product
    send_request(32'd4294967291, 32'd4294967279, n++);
    send_request(32'hAAAA_AAAA, 32'h5555_5555, n++);
    send_request(32'd7, 32'd4294967289, n++);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      random_pair(a, b);
      send_request(a, b, n++);
    end
    req_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
    end

    $display("Run covered %0d requests and %0d results, including %0d with one zero operand",
             sb.requests_noted, sb.results_checked, sb.zero_operand_requests);
    $display("and %0d with both operands zero, plus a %0d-cycle result-side hold-off.",
             sb.both_zero_requests, HOLD_OFF_CYCLES);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
src/lcm_pkg.sv
src/lcm_datapath.sv
src/lcm_ctrl.sv
src/lcm_via_euclid_gcd.sv
verif/tb.sv
